FILE: hdl/sfbs_pkg.sv
// ----------------------------------------------------------------------------
// sfbs_pkg: shared types and constants
// Field widths, side codes and the transaction record of the face sorter.
// ----------------------------------------------------------------------------
package sfbs_pkg;

  localparam int unsigned FaceW     = 38;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned SlotW     = 32;
  localparam int unsigned SideW     = 3;
  localparam int unsigned DvsW      = 2 * SizeW;      // largest divisor width
  localparam int unsigned CountW    = 3 * SizeW + 2;  // face counts and their sum
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned NumSides  = 6;
  localparam int unsigned DefMaxExtent = 4096;

  localparam logic [SideW-1:0] SIDE_IMIN = 3'd0;
  localparam logic [SideW-1:0] SIDE_IMAX = 3'd1;
  localparam logic [SideW-1:0] SIDE_JMIN = 3'd2;
  localparam logic [SideW-1:0] SIDE_JMAX = 3'd3;
  localparam logic [SideW-1:0] SIDE_KMIN = 3'd4;
  localparam logic [SideW-1:0] SIDE_KMAX = 3'd5;
  localparam logic [SideW-1:0] SIDE_NONE = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_SIZE_I = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE_J = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SIZE_K = 2'd2;

  typedef struct packed {
    logic [FaceW-1:0] face;
    logic [FaceW-1:0] donor;
    logic [SideW-1:0] side;
    logic             last;
  } item_t;

endpackage

FILE: hdl/structured_face_boundary_sorter.sv
// ----------------------------------------------------------------------------
// structured_face_boundary_sorter: boundary side sorter for structured faces
// Decodes global face indices of an i/j/k structured grid and tags each with
// its boundary side and running slot within that side.
// ----------------------------------------------------------------------------
// One transaction is in the classifier at a time. It forms the face counts in
// two multiply stages and a sum, classifies the face, then runs one 38-step
// pass of the bit-serial divider for i- and k-faces (two passes for j-faces),
// each pass started from a registered start and ending on a registered done,
// then hands the result off and returns to accept the next transaction. A
// face past the grid skips the divider. A two-entry queue and a registered
// output stage sit behind the classifier, so a stalled consumer does not stop
// the next decode until the queue fills. Sizes above MAX_EXTENT are saturated.
// Six 32-bit counters wrap and clear after the transaction flagged is_last_i.
// Size registers: index 0 i, 1 j, 2 k; write only while no transaction is
// outstanding.
module structured_face_boundary_sorter import sfbs_pkg::*; #(
  parameter int unsigned MAX_EXTENT = DefMaxExtent
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FaceW-1:0]   face_index_i,
  input  logic [FaceW-1:0]   donor_index_i,
  input  logic               is_last_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FaceW-1:0]   face_out_o,
  output logic [FaceW-1:0]   donor_out_o,
  output logic [SideW-1:0]   side_o,
  output logic [SlotW-1:0]   slot_o,
  output logic               last_out_o
);

  logic  push, full, pop, empty;
  item_t front_item, queue_item;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  sfbs_front #(.MAX_EXTENT(MAX_EXTENT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .face_index_i  (face_index_i),
    .donor_index_i (donor_index_i),
    .is_last_i     (is_last_i),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  sfbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  sfbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .face_out_o  (face_out_o),
    .donor_out_o (donor_out_o),
    .side_o      (side_o),
    .slot_o      (slot_o),
    .last_out_o  (last_out_o)
  );

endmodule

FILE: hdl/sfbs_div.sv
// ----------------------------------------------------------------------------
// sfbs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module sfbs_div import sfbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FaceW-1:0]  dividend_i,
  input  logic [DvsW-1:0]   divisor_i,
  output logic              done_o,
  output logic [FaceW-1:0]  quo_o,
  output logic [DvsW:0]     rem_o
);

  localparam logic [5:0] LastStep = 6'(FaceW - 1);

  logic [DvsW:0]    rem_q, rem_d;
  logic [FaceW-1:0] quo_q, quo_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DvsW:0]    shifted;
  logic [DvsW+1:0]  trial;

  always_comb begin
    shifted = {rem_q[DvsW-1:0], quo_q[FaceW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = trial[DvsW+1] ? shifted : trial[DvsW:0];
      quo_d = {quo_q[FaceW-2:0], ~trial[DvsW+1]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/sfbs_front.sv
// ----------------------------------------------------------------------------
// sfbs_front: accept and classify
// Holds the size registers, decodes one face index and hands the side on.
// ----------------------------------------------------------------------------
module sfbs_front import sfbs_pkg::*; #(
  parameter int unsigned MAX_EXTENT = DefMaxExtent
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FaceW-1:0]   face_index_i,
  input  logic [FaceW-1:0]   donor_index_i,
  input  logic               is_last_i,
  output logic               push_o,
  output item_t              item_o,
  input  logic               full_i
);

  // the clamp is capped at the register range, so it fits in SizeW bits
  localparam logic [SizeW-1:0] Clamp =
    (MAX_EXTENT > ((1 << SizeW) - 1)) ? SizeW'((1 << SizeW) - 1) : SizeW'(MAX_EXTENT);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD1, S_PROD2, S_SUM, S_CLASS, S_DIV1, S_DIV2, S_PUSH
  } state_e;

  typedef enum logic [1:0] {FAM_I, FAM_J, FAM_K} fam_e;

  state_e state_q, state_d;
  fam_e   fam_q, fam_d;

  logic [SizeW-1:0] size_i_q, size_j_q, size_k_q;
  logic [SizeW-1:0] ni, nj, nk, ni1, nj1, nk1;

  item_t              item_q, item_d;
  logic [DvsW-1:0]    a_q, a_d, b_q, b_d, c_q, c_d;
  logic [CountW-1:0]  n_i_q, n_i_d, n_j_q, n_j_d, n_k_q, n_k_d;
  logic [CountW-1:0]  sum_ij_q, sum_ij_d, sum_all_q, sum_all_d;
  logic [CountW-1:0]  face_ext;
  logic               start_q, start_d;
  logic [FaceW-1:0]   dvd_q, dvd_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic               done;
  logic [FaceW-1:0]   quo;
  logic [DvsW:0]      rem;

  always_comb begin
    ni  = (size_i_q > Clamp) ? Clamp : size_i_q;
    nj  = (size_j_q > Clamp) ? Clamp : size_j_q;
    nk  = (size_k_q > Clamp) ? Clamp : size_k_q;
    ni1 = (ni > SizeW'(1)) ? ni - SizeW'(1) : SizeW'(1);
    nj1 = (nj > SizeW'(1)) ? nj - SizeW'(1) : SizeW'(1);
    nk1 = (nk > SizeW'(1)) ? nk - SizeW'(1) : SizeW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_i_q <= SizeW'(2);
      size_j_q <= SizeW'(2);
      size_k_q <= SizeW'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE_I: size_i_q <= cfg_data_i;
        REG_SIZE_J: size_j_q <= cfg_data_i;
        REG_SIZE_K: size_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .done_o     (done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign face_ext = CountW'(item_q.face);

  always_comb begin
    state_d   = state_q;
    fam_d     = fam_q;
    item_d    = item_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    n_i_d     = n_i_q;
    n_j_d     = n_j_q;
    n_k_d     = n_k_q;
    sum_ij_d  = sum_ij_q;
    sum_all_d = sum_all_q;
    start_d   = 1'b0;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d.face  = face_index_i;
          item_d.donor = donor_index_i;
          item_d.last  = is_last_i;
          item_d.side  = SIDE_NONE;
          state_d      = S_PROD1;
        end
      end
      S_PROD1: begin
        a_d     = DvsW'(ni) * DvsW'(nj1);
        b_d     = DvsW'(ni1) * DvsW'(nj);
        c_d     = DvsW'(ni1) * DvsW'(nj1);
        state_d = S_PROD2;
      end
      S_PROD2: begin
        n_i_d   = CountW'(a_q) * CountW'(nk1);
        n_j_d   = CountW'(b_q) * CountW'(nk1);
        n_k_d   = CountW'(c_q) * CountW'(nk);
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_ij_d  = n_i_q + n_j_q;
        sum_all_d = n_i_q + n_j_q + n_k_q;
        state_d   = S_CLASS;
      end
      S_CLASS: begin
        start_d = 1'b1;
        state_d = S_DIV1;
        if (face_ext >= sum_all_q) begin
          start_d     = 1'b0;
          item_d.side = SIDE_NONE;
          state_d     = S_PUSH;
        end else if (face_ext >= sum_ij_q) begin
          fam_d = FAM_K;
          dvd_d = FaceW'(face_ext - sum_ij_q);
          dvs_d = c_q;
        end else if (face_ext >= n_i_q) begin
          fam_d = FAM_J;
          dvd_d = FaceW'(face_ext - n_i_q);
          dvs_d = DvsW'(ni1);
        end else begin
          fam_d = FAM_I;
          dvd_d = item_q.face;
          dvs_d = DvsW'(ni);
        end
      end
      S_DIV1: begin
        if (done) begin
          state_d = S_PUSH;
          case (fam_q)
            FAM_I: begin
              if (rem == '0)                  item_d.side = SIDE_IMIN;
              else if (rem == (DvsW+1)'(ni1)) item_d.side = SIDE_IMAX;
              else                            item_d.side = SIDE_NONE;
            end
            FAM_K: begin
              if (quo == '0)                  item_d.side = SIDE_KMIN;
              else if (quo == FaceW'(nk1))    item_d.side = SIDE_KMAX;
              else                            item_d.side = SIDE_NONE;
            end
            default: begin
              // j-face: row index first, then j is that index modulo nj
              dvd_d   = quo;
              dvs_d   = DvsW'(nj);
              start_d = 1'b1;
              state_d = S_DIV2;
            end
          endcase
        end
      end
      S_DIV2: begin
        if (done) begin
          if (rem == '0)                  item_d.side = SIDE_JMIN;
          else if (rem == (DvsW+1)'(nj1)) item_d.side = SIDE_JMAX;
          else                            item_d.side = SIDE_NONE;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      fam_q   <= FAM_I;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      fam_q   <= fam_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    n_i_q     <= n_i_d;
    n_j_q     <= n_j_d;
    n_k_q     <= n_k_d;
    sum_ij_q  <= sum_ij_d;
    sum_all_q <= sum_all_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign push_o     = (state_q == S_PUSH) && !full_i;
  assign item_o     = item_q;

endmodule

FILE: hdl/sfbs_fifo.sv
// ----------------------------------------------------------------------------
// sfbs_fifo: two-entry queue
// Decouples the classifier from the slot counter stage.
// ----------------------------------------------------------------------------
module sfbs_fifo import sfbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

FILE: hdl/sfbs_back.sv
// ----------------------------------------------------------------------------
// sfbs_back: slot counters and output register
// Assigns the running slot per side and clears the counters after a last item.
// ----------------------------------------------------------------------------
module sfbs_back import sfbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  item_t            item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [FaceW-1:0] face_out_o,
  output logic [FaceW-1:0] donor_out_o,
  output logic [SideW-1:0] side_o,
  output logic [SlotW-1:0] slot_o,
  output logic             last_out_o
);

  logic [SlotW-1:0] cnt_q [NumSides];
  logic             valid_q;
  item_t            out_q;
  logic [SlotW-1:0] slot_q, slot_d;

  assign pop_o  = !empty_i && (!valid_q || out_ready_i);
  assign slot_d = (item_i.side == SIDE_NONE) ? '0 : cnt_q[item_i.side];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int s = 0; s < NumSides; s++) cnt_q[s] <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        if (item_i.last) begin
          for (int s = 0; s < NumSides; s++) cnt_q[s] <= '0;
        end else if (item_i.side != SIDE_NONE) begin
          cnt_q[item_i.side] <= slot_d + SlotW'(1);
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q  <= item_i;
      slot_q <= slot_d;
    end
  end

  assign out_valid_o = valid_q;
  assign face_out_o  = out_q.face;
  assign donor_out_o = out_q.donor;
  assign side_o      = out_q.side;
  assign slot_o      = slot_q;
  assign last_out_o  = out_q.last;

endmodule

FILE: hdl/sfbs_checker.sv
// ----------------------------------------------------------------------------
// sfbs_assert: port-level checks
// Watches the sorter's ports over time.
// ----------------------------------------------------------------------------
module sfbs_assert import sfbs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [SideW-1:0] side_o,
  input logic [SlotW-1:0] slot_o
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transaction");

  // faces off the boundary carry no slot
  a_none_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && side_o == SIDE_NONE |-> slot_o == '0)
    else $error("slot set for side none");

  // side code stays in the defined range
  a_side_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> side_o <= SIDE_NONE)
    else $error("undefined side code");

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port stalled");

endmodule

bind structured_face_boundary_sorter sfbs_assert u_sfbs_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .side_o      (side_o),
  .slot_o      (slot_o)
);
